// ----- design/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Q1.8 unity for saturation and value
   localparam logic [8:0] SAT_ONE = 9'd256;

   // Hue sector, floor(hue * 6)
   typedef enum logic [2:0] {
      SECTOR_RED_YEL   = 3'd0,
      SECTOR_YEL_GRN   = 3'd1,
      SECTOR_GRN_CYN   = 3'd2,
      SECTOR_CYN_BLU   = 3'd3,
      SECTOR_BLU_MAG   = 3'd4,
      SECTOR_MAG_RED   = 3'd5
   } sector_type;

endpackage

// ----- design/hsv_to_rgb_pixel_top.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_top
// Four register stages lie between request accept and result valid.
// Throughput: one request per cycle; each pipeline stage holds when the stage
// after it is full and stalled, and a bubble is filled at once.
// Reset (synchronous, active high) clears all stage valid bits.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_top
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [HUE_BITS-1:0] req_hue,
   input  logic [8:0]          req_saturation,
   input  logic [8:0]          req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue
);

   localparam int HW = HUE_BITS;
   localparam logic [HW:0]   ONE_TURN   = {1'b1, {HW{1'b0}}};
   localparam logic [HW+8:0] FULL_SCALE = {1'b1, {(HW+8){1'b0}}};

   // stage handshake
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic load1, load2, load3, load4;

   assign load4     = !valid4_ff || rsp_ready;
   assign load3     = !valid3_ff || load4;
   assign load2     = !valid2_ff || load3;
   assign load1     = !valid1_ff || load2;
   assign req_ready = load1;
   assign rsp_valid = valid4_ff;

   // ---------------- stage 1: sector split, clamp ----------------
   logic [HW+2:0] hue6;
   logic [HW-1:0] frac_in;
   logic [HW:0]   frac_c_in;
   logic [8:0]    sat_in, val_in;

   assign hue6      = {1'b0, req_hue, 2'b00} + {2'b00, req_hue, 1'b0};
   assign frac_in   = hue6[HW-1:0];
   assign frac_c_in = ONE_TURN - {1'b0, frac_in};
   assign sat_in    = req_saturation[8] ? SAT_ONE : req_saturation;
   assign val_in    = req_value[8] ? SAT_ONE : req_value;

   sector_type    sector1_ff;
   logic [HW-1:0] frac1_ff;
   logic [HW:0]   frac_c1_ff;
   logic [8:0]    sat1_ff, val1_ff;

   // ---------------- stage 2: f*s, (1-f)*s, v*(1-s) ----------------
   logic [HW+8:0]  fs_in;
   logic [HW+9:0]  fcs_full;
   logic [17:0]    vp_full;

   assign fs_in    = frac1_ff * sat1_ff;
   assign fcs_full = frac_c1_ff * sat1_ff;
   assign vp_full  = val1_ff * (SAT_ONE - sat1_ff);

   sector_type     sector2_ff;
   logic [HW+8:0]  fs2_ff, fcs2_ff;
   logic [16:0]    vp2_ff;
   logic [8:0]     val2_ff;

   // ---------------- stage 3: q and t products ----------------
   logic [HW+17:0] vq_full, vt_full;

   assign vq_full = val2_ff * (FULL_SCALE - fs2_ff);
   assign vt_full = val2_ff * (FULL_SCALE - fcs2_ff);

   sector_type     sector3_ff;
   logic [HW+16:0] vq3_ff, vt3_ff;
   logic [16:0]    vp3_ff;
   logic [8:0]     val3_ff;

   // ---------------- stage 4: scale by 255, sector mux ----------------
   logic [HW+24:0] q255, t255;
   logic [24:0]    p255;
   logic [16:0]    v255;
   logic [7:0]     ch_q, ch_t, ch_p, ch_v;
   logic [7:0]     red_in, green_in, blue_in;

   assign q255 = {vq3_ff, 8'b0} - {8'b0, vq3_ff};
   assign t255 = {vt3_ff, 8'b0} - {8'b0, vt3_ff};
   assign p255 = {vp3_ff, 8'b0} - {8'b0, vp3_ff};
   assign v255 = {val3_ff, 8'b0} - {8'b0, val3_ff};
   assign ch_q = q255[HW+23:HW+16];
   assign ch_t = t255[HW+23:HW+16];
   assign ch_p = p255[23:16];
   assign ch_v = v255[15:8];

   always_comb begin
      case (sector3_ff)
         SECTOR_RED_YEL: begin
            red_in = ch_v; green_in = ch_t; blue_in = ch_p;
         end
         SECTOR_YEL_GRN: begin
            red_in = ch_q; green_in = ch_v; blue_in = ch_p;
         end
         SECTOR_GRN_CYN: begin
            red_in = ch_p; green_in = ch_v; blue_in = ch_t;
         end
         SECTOR_CYN_BLU: begin
            red_in = ch_p; green_in = ch_q; blue_in = ch_v;
         end
         SECTOR_BLU_MAG: begin
            red_in = ch_t; green_in = ch_p; blue_in = ch_v;
         end
         default: begin
            red_in = ch_v; green_in = ch_p; blue_in = ch_q;
         end
      endcase
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (load1) valid1_ff <= req_valid;
         if (load2) valid2_ff <= valid1_ff;
         if (load3) valid3_ff <= valid2_ff;
         if (load4) valid4_ff <= valid3_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load1) begin
         sector1_ff <= sector_type'(hue6[HW+2:HW]);
         frac1_ff   <= frac_in;
         frac_c1_ff <= frac_c_in;
         sat1_ff    <= sat_in;
         val1_ff    <= val_in;
      end
      if (load2) begin
         sector2_ff <= sector1_ff;
         fs2_ff     <= fs_in;
         fcs2_ff    <= fcs_full[HW+8:0];
         vp2_ff     <= vp_full[16:0];
         val2_ff    <= val1_ff;
      end
      if (load3) begin
         sector3_ff <= sector2_ff;
         vq3_ff     <= vq_full[HW+16:0];
         vt3_ff     <= vt_full[HW+16:0];
         vp3_ff     <= vp2_ff;
         val3_ff    <= val2_ff;
      end
      if (load4) begin
         rsp_red    <= red_in;
         rsp_green  <= green_in;
         rsp_blue   <= blue_in;
      end
   end

endmodule
